FILE: sv/hsi_pkg.sv
// Shared types, codes and value arithmetic for the knob panel.
`timescale 1ns / 1ps

package hsi_pkg;

	localparam int NUM_CH = 3;

	// Channel order used everywhere: intensity, saturation, hue.
	localparam int CH_INT = 0;
	localparam int CH_SAT = 1;
	localparam int CH_HUE = 2;

	// Distance a hue press moves the value.
	localparam int HUE_STEP = 64;

	localparam logic signed [8:0] PRESS_STEP = 9'(-HUE_STEP);
	localparam logic signed [8:0] DETENT_UP = 9'sd1;
	localparam logic signed [8:0] DETENT_DOWN = -9'sd1;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_HUE_MIN = 3'd0,
		REG_HUE_MAX = 3'd1,
		REG_SAT_MIN = 3'd2,
		REG_SAT_MAX = 3'd3,
		REG_INT_MIN = 3'd4,
		REG_INT_MAX = 3'd5,
		REG_WRAP    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic       wrap;
	} lane_cfg_t;

	typedef struct packed {
		logic       tick;
		logic       set;
		logic       button;
		logic       enc_a;
		logic       enc_b;
		logic [7:0] new_value;
	} lane_in_t;

	typedef struct packed {
		logic [7:0] value;
		logic       changed;
		logic       manual;
	} lane_res_t;

	typedef struct packed {
		logic [7:0] intensity;
		logic [7:0] saturation;
		logic [7:0] hue;
		logic [2:0] changed_mask;
		logic       user_action;
	} result_t;

	// Moves v by -s; an overshoot past the range either clamps or wraps round.
	function automatic logic [7:0] step_value(input logic [7:0] v, input logic signed [8:0] s,
			input logic [7:0] lo, input logic [7:0] hi, input logic wrap);
		logic signed [9:0] t;
		logic signed [9:0] lo_s;
		logic signed [9:0] hi_s;
		logic signed [9:0] w;
		logic [7:0] r;
		t = signed'({2'b00, v}) - signed'({s[8], s});
		lo_s = signed'({2'b00, lo});
		hi_s = signed'({2'b00, hi});
		r = t[7:0];
		if (!s[8] && (s != 9'sd0) && (t < lo_s)) begin
			w = hi_s - lo_s + t + 10'sd1;
			r = wrap ? w[7:0] : lo;
		end else if (s[8] && (t > hi_s)) begin
			w = lo_s + t - hi_s - 10'sd1;
			r = wrap ? w[7:0] : hi;
		end
		return r;
	endfunction

	function automatic logic [7:0] flip_value(input logic [7:0] v, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [7:0] half;
		logic [7:0] r;
		// The 8-bit difference wraps round when lo exceeds hi; it is taken for every v.
		half = (hi - lo) >> 1;
		if (v <= lo) begin
			r = hi;
		end else if (v >= hi) begin
			r = lo;
		end else if (v >= half) begin
			r = hi;
		end else begin
			r = lo;
		end
		return r;
	endfunction

	function automatic logic [7:0] limit_value(input logic [7:0] v, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [7:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: sv/hsi_if.sv
// Handshake channel interfaces for panel items, results and register writes.
`timescale 1ns / 1ps

interface hsi_req_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [2:0] button_pins;
	logic [2:0] enc_a_pins;
	logic [2:0] enc_b_pins;
	logic [1:0] channel;
	logic [7:0] new_value;

	modport source(output valid, op, button_pins, enc_a_pins, enc_b_pins, channel, new_value,
		input ready);
	modport sink(input valid, op, button_pins, enc_a_pins, enc_b_pins, channel, new_value,
		output ready);
endinterface

interface hsi_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] intensity;
	logic [7:0] saturation;
	logic [7:0] hue;
	logic [2:0] changed_mask;
	logic       user_action;

	modport source(output valid, intensity, saturation, hue, changed_mask, user_action,
		input ready);
	modport sink(input valid, intensity, saturation, hue, changed_mask, user_action,
		output ready);
endinterface

interface hsi_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/hsi_knob_panel.sv
// Top level of the three-channel hue, saturation and intensity knob panel.
// The panel takes one item in every clock cycle unless stalled and returns exactly one
// result per item from a register. Each of the three channels has its own lane holding the
// button history, the encoder phase and the channel value; a lane updates its state within
// the cycle an item is accepted, so items may follow each other without gaps. The result is
// held in an output register backed by a one-item skid stage, so the panel keeps accepting
// while a single result waits; it stalls only once both are full. Register writes are taken
// in any cycle and should arrive while no item is in flight.
`timescale 1ns / 1ps

module hsi_knob_panel #(
	parameter int DEBOUNCE_SAMPLES = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	hsi_req_if.sink  req,
	hsi_rsp_if.source rsp,
	hsi_cfg_if.sink  cfg
);

	logic [7:0] lo_q [hsi_pkg::NUM_CH];
	logic [7:0] hi_q [hsi_pkg::NUM_CH];
	logic [2:0] wrap_q;

	logic accept;
	logic merge_ready;
	hsi_pkg::lane_res_t lres [hsi_pkg::NUM_CH];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
				lo_q[i] <= 8'd0;
				hi_q[i] <= 8'd255;
			end
			wrap_q <= 3'd4;
		end else if (cfg.valid) begin
			case (hsi_pkg::cfg_reg_t'(cfg.index))
				hsi_pkg::REG_HUE_MIN: lo_q[hsi_pkg::CH_HUE] <= cfg.data;
				hsi_pkg::REG_HUE_MAX: hi_q[hsi_pkg::CH_HUE] <= cfg.data;
				hsi_pkg::REG_SAT_MIN: lo_q[hsi_pkg::CH_SAT] <= cfg.data;
				hsi_pkg::REG_SAT_MAX: hi_q[hsi_pkg::CH_SAT] <= cfg.data;
				hsi_pkg::REG_INT_MIN: lo_q[hsi_pkg::CH_INT] <= cfg.data;
				hsi_pkg::REG_INT_MAX: hi_q[hsi_pkg::CH_INT] <= cfg.data;
				hsi_pkg::REG_WRAP:    wrap_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	assign req.ready = merge_ready;
	assign accept = req.valid && merge_ready;

	for (genvar g = 0; g < hsi_pkg::NUM_CH; g++) begin : g_lane
		hsi_pkg::lane_in_t  lin;
		hsi_pkg::lane_cfg_t lcfg;

		always_comb begin
			lin.tick = accept && (hsi_pkg::op_t'(req.op) == hsi_pkg::OP_TICK);
			lin.set = accept && (hsi_pkg::op_t'(req.op) == hsi_pkg::OP_SET)
				&& (req.channel == 2'(g));
			lin.button = req.button_pins[g];
			lin.enc_a = req.enc_a_pins[g];
			lin.enc_b = req.enc_b_pins[g];
			lin.new_value = req.new_value;
			lcfg.lo = lo_q[g];
			lcfg.hi = hi_q[g];
			lcfg.wrap = wrap_q[g];
		end

		hsi_lane #(
			.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES),
			.PRESS_STEPS(g == hsi_pkg::CH_HUE)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.lin(lin),
			.lcfg(lcfg),
			.lres(lres[g])
		);
	end

	hsi_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.lres(lres),
		.ready(merge_ready),
		.rsp(rsp)
	);

endmodule

FILE: sv/hsi_lane.sv
// One channel: button debounce, quadrature decode and value update.
`timescale 1ns / 1ps

module hsi_lane #(
	parameter int DEBOUNCE_SAMPLES = 4,
	parameter bit PRESS_STEPS = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsi_pkg::lane_in_t  lin,
	input  hsi_pkg::lane_cfg_t lcfg,
	output hsi_pkg::lane_res_t lres
);

	logic [DEBOUNCE_SAMPLES-1:0] hist_q, hist_n;
	logic       down_q, down_n;
	logic [1:0] phase_q, phase_n;
	logic [1:0] acc_q, acc_n;
	logic [7:0] value_q;

	logic       press;
	logic [7:0] v_press, v_enc, v_set;
	logic [1:0] code, diff;
	logic       moved, up;
	logic       q_pos, q_neg;

	always_comb begin
		hist_n = {hist_q[DEBOUNCE_SAMPLES-2:0], ~lin.button};
		press = !down_q && (&hist_n);
		if (down_q && (hist_n == '0)) begin
			down_n = 1'b0;
		end else if (press) begin
			down_n = 1'b1;
		end else begin
			down_n = down_q;
		end

		if (!press) begin
			v_press = value_q;
		end else if (PRESS_STEPS) begin
			v_press = hsi_pkg::step_value(value_q, hsi_pkg::PRESS_STEP, lcfg.lo, lcfg.hi,
				lcfg.wrap);
		end else begin
			v_press = hsi_pkg::flip_value(value_q, lcfg.lo, lcfg.hi);
		end

		// Gray code with A as the high bit; an odd difference is one valid transition.
		code = {lin.enc_a, lin.enc_a ^ lin.enc_b};
		diff = phase_q - code;
		moved = diff[0];
		up = diff[1];
		phase_n = moved ? code : phase_q;
		// The accumulator holds 0..3 between items, so a detent is a carry out of two bits.
		acc_n = moved ? (up ? acc_q + 2'd1 : acc_q - 2'd1) : acc_q;
		q_pos = moved && up && (acc_q == 2'd3);
		q_neg = moved && !up && (acc_q == 2'd0);

		if (q_pos) begin
			v_enc = hsi_pkg::step_value(v_press, hsi_pkg::DETENT_UP, lcfg.lo, lcfg.hi,
				lcfg.wrap);
		end else if (q_neg) begin
			v_enc = hsi_pkg::step_value(v_press, hsi_pkg::DETENT_DOWN, lcfg.lo, lcfg.hi,
				lcfg.wrap);
		end else begin
			v_enc = v_press;
		end

		v_set = hsi_pkg::limit_value(lin.new_value, lcfg.lo, lcfg.hi);

		if (lin.set) begin
			lres.value = v_set;
		end else if (lin.tick) begin
			lres.value = v_enc;
		end else begin
			lres.value = value_q;
		end
		lres.changed = lin.tick && (v_enc != value_q);
		lres.manual = lin.tick && (press || q_pos || q_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			down_q  <= 1'b0;
			phase_q <= 2'd0;
			acc_q   <= 2'd0;
			value_q <= 8'd0;
		end else begin
			if (lin.tick) begin
				hist_q  <= hist_n;
				down_q  <= down_n;
				phase_q <= phase_n;
				acc_q   <= acc_n;
			end
			if (lin.tick || lin.set) begin
				value_q <= lres.value;
			end
		end
	end

endmodule

FILE: sv/hsi_merge.sv
// Merges the lane results into one item and holds it in an output register with skid.
`timescale 1ns / 1ps

module hsi_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  hsi_pkg::lane_res_t lres [hsi_pkg::NUM_CH],
	output logic               ready,
	hsi_rsp_if.source          rsp
);

	hsi_pkg::result_t res_n, out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic take;

	always_comb begin
		res_n.intensity = lres[hsi_pkg::CH_INT].value;
		res_n.saturation = lres[hsi_pkg::CH_SAT].value;
		res_n.hue = lres[hsi_pkg::CH_HUE].value;
		res_n.changed_mask = {lres[hsi_pkg::CH_HUE].changed, lres[hsi_pkg::CH_SAT].changed,
			lres[hsi_pkg::CH_INT].changed};
		res_n.user_action = lres[hsi_pkg::CH_INT].manual
			|| lres[hsi_pkg::CH_SAT].manual || lres[hsi_pkg::CH_HUE].manual;
	end

	assign ready = !skid_valid_q;
	assign take = out_valid_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (out_valid_q && !take) begin
				skid_q <= res_n;
			end else begin
				out_q <= res_n;
			end
		end else if (take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.intensity = out_q.intensity;
	assign rsp.saturation = out_q.saturation;
	assign rsp.hue = out_q.hue;
	assign rsp.changed_mask = out_q.changed_mask;
	assign rsp.user_action = out_q.user_action;

endmodule

FILE: bench/tb_hsi_knob_panel.sv
// Self-checking bench for the knob panel: random and directed items against a predictor.
`timescale 1ns / 1ps

module tb_hsi_knob_panel;

	localparam int HISTORY_LEN = 4;
	localparam logic [HISTORY_LEN-1:0] HISTORY_FULL = '1;
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam logic [2:0] PINS_RELEASED = 3'b111;
	localparam int QUIET_LIMIT = 500;
	localparam int LONG_HOLD = 60;
	localparam int PHASE_ITEMS = 265;

	typedef struct {
		hsi_pkg::op_t op;
		logic [2:0]   buttons;
		logic [2:0]   enc_a;
		logic [2:0]   enc_b;
		logic [1:0]   channel;
		logic [7:0]   new_value;
	} panel_item_t;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_MOSTLY,
		SINK_EVERY_THIRD
	} sink_pattern_t;

	logic clk;
	logic arst_n;

	hsi_req_if req_ch();
	hsi_rsp_if rsp_ch();
	hsi_cfg_if cfg_ch();

	hsi_knob_panel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the panel state and its registers.
	logic [7:0]             range_lo [hsi_pkg::NUM_CH];
	logic [7:0]             range_hi [hsi_pkg::NUM_CH];
	logic [2:0]             wrap_mask;
	logic [HISTORY_LEN-1:0] btn_history [hsi_pkg::NUM_CH];
	logic                   key_held [hsi_pkg::NUM_CH];
	logic [1:0]             phase_code [hsi_pkg::NUM_CH];
	int                     detent_acc [hsi_pkg::NUM_CH];
	logic [7:0]             pending_level [hsi_pkg::NUM_CH];
	logic [7:0]             shown_level [hsi_pkg::NUM_CH];

	hsi_pkg::result_t readouts_due[$];
	hsi_pkg::result_t due_readout;
	hsi_pkg::result_t seen_readout;

	// Stimulus generator state for well-formed button and encoder activity.
	logic [2:0] btn_level;
	int         btn_run [hsi_pkg::NUM_CH];
	logic [1:0] enc_pos [hsi_pkg::NUM_CH];
	logic [1:0] enc_dir [hsi_pkg::NUM_CH];

	int failures;
	int items_sent;
	int sets_sent;
	int regs_written;
	int readouts_checked;
	int manual_seen;
	int quiet_cycles;
	int sink_hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] step_level(input int ch, input logic [7:0] v, input int s);
		int t;
		int lo;
		int hi;
		logic [7:0] r;
		t = int'(v) - s;
		lo = range_lo[ch];
		hi = range_hi[ch];
		r = t[7:0];
		if (s > 0 && t < lo) begin
			r = wrap_mask[ch] ? 8'(hi - (lo - t) + 1) : 8'(lo);
		end else if (s < 0 && t > hi) begin
			r = wrap_mask[ch] ? 8'(lo + (t - hi) - 1) : 8'(hi);
		end
		return r;
	endfunction

	function automatic logic [7:0] flip_level(input int ch, input logic [7:0] v);
		int lo;
		int hi;
		int val;
		lo = range_lo[ch];
		hi = range_hi[ch];
		val = v;
		if (val <= lo) return 8'(hi);
		if (val >= hi) return 8'(lo);
		if (val >= (hi - lo) / 2) return 8'(hi);
		return 8'(lo);
	endfunction

	function automatic hsi_pkg::result_t predict_readout(input panel_item_t it);
		hsi_pkg::result_t r;
		logic [1:0] code;
		logic [1:0] d;
		logic [7:0] v;
		logic manual;
		logic [2:0] mask;
		int a;
		int q;
		manual = 1'b0;
		mask = 3'b000;
		if (it.op == hsi_pkg::OP_SET) begin
			if (it.channel < hsi_pkg::NUM_CH) begin
				v = it.new_value;
				if (v < range_lo[it.channel]) begin
					v = range_lo[it.channel];
				end else if (v > range_hi[it.channel]) begin
					v = range_hi[it.channel];
				end
				pending_level[it.channel] = v;
				shown_level[it.channel] = v;
			end
		end else begin
			for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
				btn_history[i] = {btn_history[i][HISTORY_LEN-2:0], ~it.buttons[i]};
				if (!key_held[i] && btn_history[i] == HISTORY_FULL) begin
					key_held[i] = 1'b1;
					manual = 1'b1;
					pending_level[i] = (i == hsi_pkg::CH_HUE) ?
						step_level(i, pending_level[i], -hsi_pkg::HUE_STEP) :
						flip_level(i, pending_level[i]);
				end
				if (key_held[i] && btn_history[i] == '0) key_held[i] = 1'b0;
			end
			for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
				code = {it.enc_a[i], it.enc_a[i] ^ it.enc_b[i]};
				d = phase_code[i] - code;
				if (d[0]) begin
					phase_code[i] = code;
					detent_acc[i] += d[1] ? 1 : -1;
				end
			end
			// Whole detents are taken off the accumulator by floor division.
			for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
				a = detent_acc[i];
				q = (a >= 0) ? a / 4 : -((-a + 3) / 4);
				if (q != 0) begin
					detent_acc[i] = a - 4 * q;
					manual = 1'b1;
					pending_level[i] = step_level(i, pending_level[i], q);
				end
			end
		end
		for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
			if (shown_level[i] != pending_level[i]) begin
				shown_level[i] = pending_level[i];
				mask[i] = 1'b1;
			end
		end
		r.intensity = shown_level[hsi_pkg::CH_INT];
		r.saturation = shown_level[hsi_pkg::CH_SAT];
		r.hue = shown_level[hsi_pkg::CH_HUE];
		r.changed_mask = mask;
		r.user_action = manual;
		return r;
	endfunction

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= 10) $display("%s", msg);
	endtask

	task automatic send_item(input panel_item_t it);
		req_ch.valid <= 1'b1;
		req_ch.op <= it.op;
		req_ch.button_pins <= it.buttons;
		req_ch.enc_a_pins <= it.enc_a;
		req_ch.enc_b_pins <= it.enc_b;
		req_ch.channel <= it.channel;
		req_ch.new_value <= it.new_value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		readouts_due.push_back(predict_readout(it));
		items_sent++;
		if (it.op == hsi_pkg::OP_SET) sets_sent++;
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		regs_written++;
		case (index)
			hsi_pkg::REG_HUE_MIN: range_lo[hsi_pkg::CH_HUE] = data;
			hsi_pkg::REG_HUE_MAX: range_hi[hsi_pkg::CH_HUE] = data;
			hsi_pkg::REG_SAT_MIN: range_lo[hsi_pkg::CH_SAT] = data;
			hsi_pkg::REG_SAT_MAX: range_hi[hsi_pkg::CH_SAT] = data;
			hsi_pkg::REG_INT_MIN: range_lo[hsi_pkg::CH_INT] = data;
			hsi_pkg::REG_INT_MAX: range_hi[hsi_pkg::CH_INT] = data;
			hsi_pkg::REG_WRAP:    wrap_mask = data[2:0];
			default: ;
		endcase
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (readouts_due.size() != 0) @(posedge clk);
	endtask

	// Registers are only rewritten once every outstanding item has been answered.
	task automatic load_ranges(input logic [7:0] hue_lo, input logic [7:0] hue_hi,
			input logic [7:0] sat_lo, input logic [7:0] sat_hi, input logic [7:0] int_lo,
			input logic [7:0] int_hi, input logic [7:0] wrap_data, input bit poke_spare);
		drain_results();
		write_reg(hsi_pkg::REG_HUE_MIN, hue_lo);
		write_reg(hsi_pkg::REG_HUE_MAX, hue_hi);
		write_reg(hsi_pkg::REG_SAT_MIN, sat_lo);
		write_reg(hsi_pkg::REG_SAT_MAX, sat_hi);
		write_reg(hsi_pkg::REG_INT_MIN, int_lo);
		write_reg(hsi_pkg::REG_INT_MAX, int_hi);
		write_reg(hsi_pkg::REG_WRAP, wrap_data);
		if (poke_spare) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic tick(input logic [2:0] buttons, input logic [2:0] enc_a,
			input logic [2:0] enc_b);
		panel_item_t it;
		it.op = hsi_pkg::OP_TICK;
		it.buttons = buttons;
		it.enc_a = enc_a;
		it.enc_b = enc_b;
		it.channel = 2'($urandom_range(0, 3));
		it.new_value = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic remote_set(input logic [1:0] ch, input logic [7:0] value);
		panel_item_t it;
		it.op = hsi_pkg::OP_SET;
		it.buttons = 3'($urandom_range(0, 7));
		it.enc_a = 3'($urandom_range(0, 7));
		it.enc_b = 3'($urandom_range(0, 7));
		it.channel = ch;
		it.new_value = value;
		send_item(it);
	endtask

	// Mostly ticks with held or bouncing buttons, encoder steps and rare illegal jumps; some remote sets.
	task automatic random_item();
		panel_item_t it;
		int roll;
		it.channel = 2'($urandom_range(0, 3));
		it.new_value = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 8) begin
			it.op = hsi_pkg::OP_SET;
			it.buttons = 3'($urandom_range(0, 7));
			it.enc_a = 3'($urandom_range(0, 7));
			it.enc_b = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: it.new_value = 8'd0;
				1: it.new_value = 8'd255;
				default: ;
			endcase
		end else begin
			it.op = hsi_pkg::OP_TICK;
			for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
				if (btn_run[i] == 0) begin
					btn_level[i] = ~btn_level[i];
					btn_run[i] = $urandom_range(1, 9);
				end
				btn_run[i]--;
				it.buttons[i] = btn_level[i];
				roll = $urandom_range(0, 99);
				if (roll < 2) enc_dir[i] = -enc_dir[i];
				if (roll < 45) begin
					enc_pos[i] += enc_dir[i];
				end else if (roll < 55) begin
					enc_pos[i] -= enc_dir[i];
				end else if (roll < 59) begin
					enc_pos[i] += 2'd2;
				end
				it.enc_a[i] = enc_pos[i][1];
				it.enc_b[i] = enc_pos[i][1] ^ enc_pos[i][0];
			end
		end
		send_item(it);
	endtask

	task automatic run_items(input int count);
		int burst_left;
		int gap;
		burst_left = 0;
		repeat (count) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) :
					$urandom_range(1, 20);
				gap = $urandom_range(1, 8);
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
			random_item();
		end
	endtask

	task automatic test_reset_state();
		tick(PINS_RELEASED, 3'b000, 3'b000);
	endtask

	task automatic test_remote_set();
		remote_set(2'(hsi_pkg::CH_INT), 8'd255);
		remote_set(2'(hsi_pkg::CH_SAT), 8'd0);
		remote_set(2'(hsi_pkg::CH_HUE), 8'd224);
		remote_set(2'd3, 8'd77);
	endtask

	// A bounced press, a clean press of all keys, then a full release, while intensity
	// turns forwards, saturation backwards and hue makes only illegal jumps.
	task automatic test_press_and_detents();
		logic [1:0] fwd;
		logic [1:0] back;
		logic [1:0] jump;
		logic [2:0] buttons;
		for (int k = 1; k <= 12; k++) begin
			fwd = 2'(k);
			back = 2'(-k);
			jump = (k % 2 == 0) ? 2'd2 : 2'd0;
			buttons = (k == 4 || k >= 9) ? PINS_RELEASED : 3'b000;
			tick(buttons, {jump[1], back[1], fwd[1]},
				{jump[1] ^ jump[0], back[1] ^ back[0], fwd[1] ^ fwd[0]});
		end
	endtask

	// The receiver holds off while items keep coming, so the panel has to stall its input.
	task automatic test_output_stall();
		drain_results();
		sink_hold_request = LONG_HOLD;
		repeat (30) random_item();
		drain_results();
	endtask

	task automatic test_config_sweep();
		load_ranges(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'h07, 1'b0);
		run_items(PHASE_ITEMS);
		load_ranges(8'd16, 8'd240, 8'd16, 8'd240, 8'd16, 8'd240, 8'h00, 1'b0);
		run_items(PHASE_ITEMS);
		load_ranges(8'd200, 8'd50, 8'd180, 8'd20, 8'd255, 8'd0, 8'hFD, 1'b1);
		run_items(PHASE_ITEMS);
		load_ranges(8'd128, 8'd128, 8'd0, 8'd0, 8'd255, 8'd255, 8'h02, 1'b0);
		run_items(PHASE_ITEMS);
		load_ranges(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b1);
		run_items(PHASE_ITEMS);
		load_ranges(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'h04, 1'b0);
		run_items(PHASE_ITEMS);
	endtask

	// Each result is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			readouts_checked++;
			seen_readout.intensity = rsp_ch.intensity;
			seen_readout.saturation = rsp_ch.saturation;
			seen_readout.hue = rsp_ch.hue;
			seen_readout.changed_mask = rsp_ch.changed_mask;
			seen_readout.user_action = rsp_ch.user_action;
			if (seen_readout.user_action === 1'b1) manual_seen++;
			if (readouts_due.size() == 0) begin
				log_failure($sformatf("Result %0d arrived with nothing outstanding.",
					readouts_checked));
			end else begin
				due_readout = readouts_due.pop_front();
				if (seen_readout.intensity !== due_readout.intensity ||
						seen_readout.saturation !== due_readout.saturation ||
						seen_readout.hue !== due_readout.hue ||
						seen_readout.changed_mask !== due_readout.changed_mask ||
						seen_readout.user_action !== due_readout.user_action) begin
					log_failure($sformatf({"Result %0d: expected I=%0d S=%0d H=%0d ",
						"mask=%b action=%b, got I=%0d S=%0d H=%0d mask=%b action=%b"},
						readouts_checked, due_readout.intensity, due_readout.saturation,
						due_readout.hue, due_readout.changed_mask,
						due_readout.user_action, seen_readout.intensity,
						seen_readout.saturation, seen_readout.hue,
						seen_readout.changed_mask, seen_readout.user_action));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Nothing accepted for %0d cycles.", QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: changes its stall pattern now and then, and serves long hold requests.
	initial begin
		sink_pattern_t pattern;
		int pattern_left;
		int hold_left;
		int sink_tick;
		pattern = SINK_OPEN;
		pattern_left = 0;
		hold_left = 0;
		sink_tick = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			sink_tick++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (sink_hold_request > 0) begin
				hold_left = sink_hold_request - 1;
				sink_hold_request = 0;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern = sink_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(20, 200);
				end
				pattern_left--;
				case (pattern)
					SINK_OPEN:   rsp_ch.ready <= 1'b1;
					SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					SINK_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
					default:     rsp_ch.ready <= (sink_tick % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.op <= hsi_pkg::OP_TICK;
		req_ch.button_pins <= PINS_RELEASED;
		req_ch.enc_a_pins <= 3'b000;
		req_ch.enc_b_pins <= 3'b000;
		req_ch.channel <= 2'd0;
		req_ch.new_value <= 8'd0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= hsi_pkg::REG_HUE_MIN;
		cfg_ch.data <= 8'd0;
		failures = 0;
		items_sent = 0;
		sets_sent = 0;
		regs_written = 0;
		readouts_checked = 0;
		manual_seen = 0;
		quiet_cycles = 0;
		sink_hold_request = 0;
		wrap_mask = 3'b100;
		btn_level = PINS_RELEASED;
		for (int i = 0; i < hsi_pkg::NUM_CH; i++) begin
			range_lo[i] = 8'd0;
			range_hi[i] = 8'd255;
			btn_history[i] = '0;
			key_held[i] = 1'b0;
			phase_code[i] = 2'd0;
			detent_acc[i] = 0;
			pending_level[i] = 8'd0;
			shown_level[i] = 8'd0;
			btn_run[i] = 0;
			enc_pos[i] = 2'd0;
			enc_dir[i] = 2'd1;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_remote_set();
		test_press_and_detents();
		test_output_stall();
		test_config_sweep();

		drain_results();
		repeat (8) @(posedge clk);
		$display({"Ran %0d items (%0d remote sets) across six range and wrap settings, ",
			"%0d register writes."}, items_sent, sets_sent, regs_written);
		$display("Checked %0d results, %0d with a manual action; %0d mismatches.",
			readouts_checked, manual_seen, failures);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/hsi_pkg.sv
sv/hsi_if.sv
sv/hsi_lane.sv
sv/hsi_merge.sv
sv/hsi_knob_panel.sv
bench/tb_hsi_knob_panel.sv
